>>> hdl/dq_pkg.sv
// package: shared constants, codes and types for the double-ended queue
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CNT_W_DEF      = $clog2(DEPTH_DEF + 1);

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  // operation broadcast to every cell of the row
  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_REAR  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_REAR   = 3'd4
  } cell_op_t;

endpackage

>>> hdl/dq_if.sv
// interfaces: request and response channels of the double-ended queue
`timescale 1ns / 1ps

interface dq_req_if #(
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic signed [DATA_WIDTH-1:0] item_value;

  modport source (output valid, output mode, output item_value, input ready);
  modport sink   (input valid, input mode, input item_value, output ready);
endinterface

interface dq_rsp_if #(
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
  parameter int CNT_W      = dq_pkg::CNT_W_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] popped_value;
  logic [1:0]                   status;
  logic [CNT_W-1:0]             occupancy;

  modport source (output valid, output popped_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input occupancy,
                  output ready);
endinterface

>>> hdl/dq_cell.sv
// one cell of the deque row: a word, its valid bit and the neighbor shift logic
`timescale 1ns / 1ps

module dq_cell #(
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dq_pkg::cell_op_t      op,
  input  logic [DATA_WIDTH-1:0] push_word,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_valid,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  right_valid,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  valid,
  output logic [DATA_WIDTH-1:0] tap
);
  import dq_pkg::*;

  logic [DATA_WIDTH-1:0] data_next;
  logic                  valid_next;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    unique case (op)
      OP_HOLD: begin
      end
      OP_PUSH_FRONT: begin
        data_next  = left_data;
        valid_next = left_valid;
      end
      OP_POP_FRONT: begin
        data_next  = right_data;
        valid_next = right_valid;
      end
      OP_PUSH_REAR: begin
        // first empty cell behind the occupied run takes the word
        if (!valid && left_valid) begin
          data_next  = push_word;
          valid_next = 1'b1;
        end
      end
      OP_POP_REAR: begin
        if (valid && !right_valid) begin
          valid_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // only the last occupied cell shows its word to the rear read
  assign tap = (valid && !right_valid) ? data : '0;

endmodule

>>> hdl/double_ended_queue.sv
// top level: double-ended queue built as a shifting row of cells
//
// req carries mode (push front, push rear, pop front, pop rear) and item_value;
// a transfer happens when valid and ready are both high. rsp returns one item
// per request: popped_value, status (ok, underflow, overflow) and occupancy.
// rsp.valid rises in the cycle after the request transfer; one request is taken
// every cycle unless rsp stalls. the row of cells updates together, the front
// word sits in cell 0 and the rear word is picked from the last occupied cell.
// the response register holds its item while rsp.ready is low; req.ready then
// drops until that item is taken, so nothing is lost or repeated.
// a push onto a full queue is dropped with overflow, a pop from an empty queue
// returns all ones with underflow; neither changes the stored words.
// synchronous reset empties the queue and clears the response valid; the
// stored words themselves are not cleared.
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input logic     clk,
  input logic     rst,
  dq_req_if.sink  req,
  dq_rsp_if.source rsp
);
  import dq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic                  cell_valid [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tap [DEPTH];
  logic [DATA_WIDTH-1:0] rear_word;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  fire;
  logic                  full;
  logic                  empty;
  cell_op_t              op;
  mode_t                 mode;

  logic [DATA_WIDTH-1:0] popped_value_next;
  status_t               status_next;

  assign req.ready = !rsp.valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign mode      = mode_t'(req.mode);
  assign full      = (count == FULL_CNT);
  assign empty     = (count == '0);

  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | cell_tap[i];
    end
  end

  always_comb begin
    op                = OP_HOLD;
    count_next        = count;
    popped_value_next = '0;
    status_next       = ST_OK;
    unique case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
        if (full) begin
          status_next = ST_OVER;
        end else begin
          op         = (mode == MODE_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_REAR;
          count_next = count + 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_POP_REAR: begin
        if (empty) begin
          status_next       = ST_UNDER;
          popped_value_next = '1;
        end else if (mode == MODE_POP_FRONT) begin
          op                = OP_POP_FRONT;
          popped_value_next = cell_data[0];
          count_next        = count - 1'b1;
        end else begin
          op                = OP_POP_REAR;
          popped_value_next = rear_word;
          count_next        = count - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!fire) begin
      op = OP_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic                  left_valid;
    logic [DATA_WIDTH-1:0] right_data;
    logic                  right_valid;

    if (i == 0) begin : g_first
      // the pushed word enters the row from the front side
      assign left_data  = req.item_value;
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    dq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .push_word   (req.item_value),
      .left_data   (left_data),
      .left_valid  (left_valid),
      .right_data  (right_data),
      .right_valid (right_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .tap         (cell_tap[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (fire) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.popped_value <= popped_value_next;
      rsp.status       <= status_next;
      rsp.occupancy    <= count_next;
    end
  end

endmodule

>>> bench/tb_top.sv
// testbench: directed table then biased random traffic against a deque predictor
`timescale 1ns / 1ps

module tb_top;
  import dq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int DW          = DATA_WIDTH_DEF;
  localparam int CW          = CNT_W_DEF;
  localparam int IW          = $clog2(DEPTH);
  localparam int RAND_OPS    = 1500;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic [DW-1:0] popped_value;
    status_t       status;
    logic [CW-1:0] occupancy;
  } deque_result_t;

  typedef struct packed {
    mode_t         op;
    logic [DW-1:0] word;
    bit            typed;
    deque_result_t typed_res;
  } directed_row_t;

  localparam deque_result_t NO_RES    = '{'0, ST_OK, '0};
  localparam deque_result_t UNDER_RES = '{'1, ST_UNDER, '0};
  localparam deque_result_t OVER_RES  = '{'0, ST_OVER, CW'(DEPTH)};

  // underflow on both ends, fill to full with extreme words, overflow on both ends, then pop both ends
  localparam directed_row_t DIRECTED_ROWS [22] = '{
    '{MODE_POP_FRONT,  32'h0000_0000, 1'b1, UNDER_RES},
    '{MODE_POP_REAR,   32'h0000_0000, 1'b1, UNDER_RES},
    '{MODE_PUSH_FRONT, 32'h7fff_ffff, 1'b0, NO_RES},
    '{MODE_PUSH_REAR,  32'h8000_0000, 1'b0, NO_RES},
    '{MODE_PUSH_FRONT, 32'hffff_ffff, 1'b0, NO_RES},
    '{MODE_PUSH_REAR,  32'h0000_0000, 1'b0, NO_RES},
    '{MODE_PUSH_FRONT, 32'h0000_0001, 1'b0, NO_RES},
    '{MODE_PUSH_REAR,  32'hffff_fffe, 1'b0, NO_RES},
    '{MODE_PUSH_FRONT, 32'h5555_5555, 1'b0, NO_RES},
    '{MODE_PUSH_REAR,  32'haaaa_aaaa, 1'b0, NO_RES},
    '{MODE_PUSH_FRONT, 32'h1234_5678, 1'b0, NO_RES},
    '{MODE_PUSH_REAR,  32'h8765_4321, 1'b0, NO_RES},
    '{MODE_PUSH_FRONT, 32'h00ff_00ff, 1'b0, NO_RES},
    '{MODE_PUSH_REAR,  32'hff00_ff00, 1'b0, NO_RES},
    '{MODE_PUSH_FRONT, 32'h7fff_fffe, 1'b0, NO_RES},
    '{MODE_PUSH_REAR,  32'h8000_0001, 1'b0, NO_RES},
    '{MODE_PUSH_FRONT, 32'h0f0f_0f0f, 1'b0, NO_RES},
    '{MODE_PUSH_REAR,  32'hf0f0_f0f0, 1'b0, NO_RES},
    '{MODE_PUSH_FRONT, 32'hdead_beef, 1'b1, OVER_RES},
    '{MODE_PUSH_REAR,  32'hcafe_f00d, 1'b1, OVER_RES},
    '{MODE_POP_FRONT,  32'h0000_0000, 1'b0, NO_RES},
    '{MODE_POP_REAR,   32'h0000_0000, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst;

  dq_req_if req_ch ();
  dq_rsp_if rsp_ch ();

  double_ended_queue u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #1 clk = ~clk;

  // predictor state: ring of words, front position and fill level
  logic [DW-1:0] ring_words [DEPTH];
  logic [IW-1:0] front_pos;
  logic [CW-1:0] fill_level;

  deque_result_t pending_results [$];
  int            error_count;
  int            op_count [4];
  int            checked_count;
  int            overflow_seen;
  int            underflow_seen;
  int            peak_fill;
  int            quiet_cycles;
  bit            calm_stretch;

  function automatic deque_result_t apply_deque_op(input mode_t op, input logic [DW-1:0] word);
    deque_result_t res;
    logic [IW-1:0] slot;
    res = '{'0, ST_OK, '0};
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
        if (fill_level == CW'(DEPTH)) begin
          res.status = ST_OVER;
        end else begin
          if (op == MODE_PUSH_FRONT) begin
            front_pos = front_pos - 1'b1;
            slot = front_pos;
          end else begin
            slot = front_pos + fill_level[IW-1:0];
          end
          ring_words[slot] = word;
          fill_level = fill_level + 1'b1;
        end
      end
      default: begin
        if (fill_level == '0) begin
          res.status = ST_UNDER;
          res.popped_value = '1;
        end else if (op == MODE_POP_FRONT) begin
          res.popped_value = ring_words[front_pos];
          front_pos = front_pos + 1'b1;
          fill_level = fill_level - 1'b1;
        end else begin
          // full deque: low bits of the count wrap, so this still lands on the rear
          slot = front_pos + fill_level[IW-1:0] - 1'b1;
          res.popped_value = ring_words[slot];
          fill_level = fill_level - 1'b1;
        end
      end
    endcase
    res.occupancy = fill_level;
    if (int'(fill_level) > peak_fill) peak_fill = int'(fill_level);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    error_count++;
  endtask

  task automatic send_op(input mode_t op, input logic [DW-1:0] word, input bit typed,
                         input deque_result_t typed_res);
    deque_result_t predicted;
    while (!calm_stretch && $urandom_range(0, 99) < 11) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= op;
    req_ch.item_value <= word;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_deque_op(op, word);
    pending_results.push_back(typed ? typed_res : predicted);
    op_count[op]++;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // response side: random back-pressure, checked against the oldest expectation
  always @(posedge clk) begin
    deque_result_t want;
    rsp_ch.ready <= calm_stretch || ($urandom_range(0, 99) >= 11);
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      checked_count++;
      if (rsp_ch.status == ST_OVER) overflow_seen++;
      if (rsp_ch.status == ST_UNDER) underflow_seen++;
      if (pending_results.size() == 0) begin
        $display("[%0t] response transfer with nothing expected", $time);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.popped_value !== want.popped_value)
          report_mismatch("popped_value", rsp_ch.popped_value, want.popped_value);
        if (rsp_ch.status !== want.status)
          report_mismatch("status", DW'(rsp_ch.status), DW'(want.status));
        if (rsp_ch.occupancy !== want.occupancy)
          report_mismatch("occupancy", DW'(rsp_ch.occupancy), DW'(want.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("double_ended_queue regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int            sent;
    int            burst_len;
    int            push_pct;
    mode_t         op;
    logic [DW-1:0] word;

    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.mode       <= MODE_PUSH_FRONT;
    req_ch.item_value <= '0;
    front_pos      = '0;
    fill_level     = '0;
    error_count    = 0;
    checked_count  = 0;
    overflow_seen  = 0;
    underflow_seen = 0;
    peak_fill      = 0;
    calm_stretch   = 1'b0;
    foreach (op_count[i]) op_count[i] = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i])
      send_op(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed,
              DIRECTED_ROWS[i].typed_res);

    // hold off until the directed responses are all back
    req_ch.valid <= 1'b0;
    drain_results();

    // bursts with a varying push bias sweep the fill level between empty and full
    sent = 0;
    while (sent < RAND_OPS) begin
      burst_len = $urandom_range(8, 40);
      case ($urandom_range(0, 4))
        0: push_pct = 5;
        1: push_pct = 25;
        2: push_pct = 50;
        3: push_pct = 75;
        default: push_pct = 95;
      endcase
      repeat (burst_len) begin
        calm_stretch = (sent >= 400 && sent < 700);
        if ($urandom_range(0, 99) < push_pct)
          op = mode_t'($urandom_range(0, 1));
        else
          op = mode_t'(2 + $urandom_range(0, 1));
        case ($urandom_range(0, 11))
          0: word = 32'h7fff_ffff;
          1: word = 32'h8000_0000;
          2: word = '1;
          3: word = '0;
          default: word = $urandom;
        endcase
        send_op(op, word, 1'b0, NO_RES);
        sent++;
      end
      if (sent >= RAND_OPS / 2 && sent - burst_len < RAND_OPS / 2) begin
        req_ch.valid <= 1'b0;
        drain_results();
      end
    end
    calm_stretch = 1'b0;
    req_ch.valid <= 1'b0;

    drain_results();
    repeat (5) @(posedge clk);

    $display("sent %0d push front, %0d push rear, %0d pop front, %0d pop rear",
             op_count[MODE_PUSH_FRONT], op_count[MODE_PUSH_REAR],
             op_count[MODE_POP_FRONT], op_count[MODE_POP_REAR]);
    $display("checked %0d responses: %0d overflow, %0d underflow, peak fill %0d of %0d",
             checked_count, overflow_seen, underflow_seen, peak_fill, DEPTH);
    if (error_count == 0) begin
      $display("double_ended_queue regression: pass");
    end else begin
      $display("double_ended_queue regression: fail");
    end
    $finish;
  end

endmodule
